// ===== rtl/edrs_pkg.sv =====
// Package for the disk request scheduler: field widths, codes and shared types.
// No dependencies.
package edrs_pkg;
	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_SECTORS_PER_TRACK = 16;
	localparam int DEF_SECTOR_BYTES = 512;

	localparam logic [1:0] OP_READ = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_SIZE = 2'd2;
	localparam logic [1:0] OP_DONE = 2'd3;

	localparam logic [1:0] RK_CMD = 2'd0;
	localparam logic [1:0] RK_DONE = 2'd1;
	localparam logic [1:0] RK_REJECT = 2'd2;

	localparam logic [1:0] CMD_SEEK = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_SIZE = 2'd3;

	localparam int IN_W = 2 + 16 + 5 + 16 + 32 + 8 + 1 + 16;
	localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W = 2 + 2 + 16 + 32 + 8 + 1 + 16;
	localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

	typedef struct packed {
		logic [15:0] track_total;
		logic        done_status;
		logic [7:0]  done_tag;
		logic [31:0] command_buffer;
		logic [15:0] command_argument;
		logic [1:0]  command;
		logic [1:0]  result_kind;
	} result_t;
endpackage

// ===== rtl/edrs_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
module edrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/elevator_disk_request_scheduler_top.sv =====
// Disk request scheduler: the sorted insert walks the list one entry at a time, each entry
// passing through a WALK and a WALKC state around the registered RAM read.
// A waiting output word holds the scheduler in ST_OUT until it is taken.
// Not ready while a word is in work. Reset empties all lists and frees every slot;
// the entry RAM holds no reset value. Depends on edrs_pkg and edrs_ram.
module elevator_disk_request_scheduler_top #(
	parameter int QUEUE_DEPTH = edrs_pkg::DEF_QUEUE_DEPTH,
	parameter int SECTORS_PER_TRACK = edrs_pkg::DEF_SECTORS_PER_TRACK,
	parameter int SECTOR_BYTES = edrs_pkg::DEF_SECTOR_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// operation, track, start_sector, sector_count, buffer_address, request_tag,
	// completion_status, track_count
	input  logic [edrs_pkg::IN_BYTES_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// result_kind, command, command_argument, command_buffer, done_tag, done_status,
	// track_total
	output logic [edrs_pkg::OUT_BYTES_W-1:0] m_tdata,
	output logic                             m_tlast
);
	import edrs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] NONE = PW'(QUEUE_DEPTH);
	localparam int EW = 2 + 16 + 16 + 16 + 32 + 8 + PW;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC = 4'd1;
	localparam logic [3:0] ST_WALK = 4'd2;
	localparam logic [3:0] ST_WALKC = 4'd3;
	localparam logic [3:0] ST_LINK = 4'd4;
	localparam logic [3:0] ST_DISP = 4'd5;
	localparam logic [3:0] ST_RDA = 4'd6;
	localparam logic [3:0] ST_ISSUE = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;
	localparam logic [3:0] ST_CRD = 4'd9;
	localparam logic [3:0] ST_CMP = 4'd10;
	localparam logic [3:0] ST_UPD = 4'd11;
	localparam logic [3:0] ST_LINKP = 4'd12;

	typedef struct packed {
		logic [1:0]    kind;
		logic [15:0]   trk;
		logic [15:0]   sec;
		logic [15:0]   rem;
		logic [31:0]   buff;
		logic [7:0]    tag;
		logic [PW-1:0] link;
	} entry_t;

	logic [3:0] state_q, ret_q;
	logic [1:0] op_q;
	logic [15:0] trk_q, cnt_q, tracks_q;
	logic [4:0] sec_q;
	logic [31:0] buf_q;
	logic [7:0] tag_q;
	logic stat_q;

	logic [QUEUE_DEPTH-1:0] free_q;
	logic [PW-1:0] size_head_q, sweep_head_q, wrap_head_q, active_q;
	logic [15:0] head_track_q;
	logic busy_q;
	logic [1:0] issued_q;

	logic [PW-1:0] new_q, cur_q, prev_q;
	logic use_sweep_q;
	entry_t ent_q;

	result_t res_q;
	logic out_last_q, out_v_q;
	logic pend_last_q;
	result_t pend_res_q;
	logic out_load;

	logic we;
	logic [AW-1:0] waddr, raddr;
	entry_t wdata, rdata;
	entry_t step_ent;

	edrs_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [PW-1:0] first_free;
	always_comb begin
		first_free = NONE;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
			if (free_q[i])
				first_free = PW'(i);
	end

	logic bad;
	assign bad = (op_q != OP_SIZE) && ((16'(sec_q) >= 16'(SECTORS_PER_TRACK)) ||
		(cnt_q == '0) || (buf_q == '0));

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tlast = out_last_q;
	assign m_tdata = OUT_BYTES_W'(res_q);
	assign out_load = (state_q == ST_OUT) && (!out_v_q || m_tready);

	logic [15:0] nsec;
	assign nsec = rdata.sec + 16'd1;

	always_comb begin
		step_ent = rdata;
		if (issued_q != CMD_SEEK) begin
			step_ent.rem = rdata.rem - 16'd1;
			step_ent.buff = rdata.buff + 32'(SECTOR_BYTES);
			if (nsec >= 16'(SECTORS_PER_TRACK)) begin
				step_ent.sec = '0;
				step_ent.trk = rdata.trk + 16'd1;
			end else
				step_ent.sec = nsec;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = cur_q[AW-1:0];
		wdata = ent_q;
		raddr = cur_q[AW-1:0];
		unique case (state_q)
			ST_DEC: begin
				waddr = first_free[AW-1:0];
				wdata.kind = op_q;
				wdata.tag = tag_q;
				wdata.trk = (op_q == OP_SIZE) ? 16'd0 : trk_q;
				wdata.sec = (op_q == OP_SIZE) ? 16'd0 : 16'(sec_q);
				wdata.rem = (op_q == OP_SIZE) ? 16'd0 : cnt_q;
				wdata.buff = (op_q == OP_SIZE) ? 32'd0 : buf_q;
				wdata.link = size_head_q;
				we = !bad && first_free != NONE && op_q == OP_SIZE;
			end
			ST_LINK: begin
				we = 1'b1;
				waddr = new_q[AW-1:0];
				wdata.kind = op_q;
				wdata.tag = tag_q;
				wdata.trk = trk_q;
				wdata.sec = 16'(sec_q);
				wdata.rem = cnt_q;
				wdata.buff = buf_q;
				wdata.link = cur_q;
			end
			ST_LINKP: begin
				we = 1'b1;
				waddr = prev_q[AW-1:0];
				wdata.link = new_q;
			end
			ST_UPD: begin
				we = 1'b1;
				waddr = active_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			free_q <= '1;
			size_head_q <= NONE;
			sweep_head_q <= NONE;
			wrap_head_q <= NONE;
			active_q <= NONE;
			head_track_q <= '0;
			busy_q <= 1'b0;
			issued_q <= CMD_SEEK;
			out_v_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q <= s_tdata[1:0];
						trk_q <= s_tdata[17:2];
						sec_q <= s_tdata[22:18];
						cnt_q <= s_tdata[38:23];
						buf_q <= s_tdata[70:39];
						tag_q <= s_tdata[78:71];
						stat_q <= s_tdata[79];
						tracks_q <= s_tdata[95:80];
						state_q <= (s_tdata[1:0] == OP_DONE) ? ST_CRD : ST_DEC;
						cur_q <= active_q;
					end
				end
				ST_DEC: begin
					if (bad || first_free == NONE) begin
						pend_res_q <= '{result_kind: RK_REJECT, done_tag: tag_q, default: '0};
						pend_last_q <= 1'b1;
						ret_q <= ST_IDLE;
						state_q <= ST_OUT;
					end else begin
						free_q[first_free[AW-1:0]] <= 1'b0;
						new_q <= first_free;
						if (op_q == OP_SIZE) begin
							size_head_q <= first_free;
							state_q <= ST_DISP;
						end else begin
							use_sweep_q <= trk_q >= head_track_q;
							cur_q <= (trk_q >= head_track_q) ? sweep_head_q : wrap_head_q;
							prev_q <= NONE;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: state_q <= (cur_q == NONE) ? ST_LINK : ST_WALKC;
				ST_WALKC: begin
					if (rdata.trk < trk_q) begin
						ent_q <= rdata;
						prev_q <= cur_q;
						cur_q <= rdata.link;
						state_q <= ST_WALK;
					end else
						state_q <= ST_LINK;
				end
				ST_LINK: begin
					if (prev_q == NONE) begin
						if (use_sweep_q)
							sweep_head_q <= new_q;
						else
							wrap_head_q <= new_q;
						state_q <= ST_DISP;
					end else
						state_q <= ST_LINKP;
				end
				ST_LINKP: state_q <= ST_DISP;
				ST_DISP: begin
					if (busy_q || (size_head_q == NONE && sweep_head_q == NONE &&
						wrap_head_q == NONE)) begin
						state_q <= ST_IDLE;
					end else begin
						if (size_head_q != NONE)
							cur_q <= size_head_q;
						else if (sweep_head_q != NONE)
							cur_q <= sweep_head_q;
						else begin
							cur_q <= wrap_head_q;
							wrap_head_q <= NONE;
						end
						state_q <= ST_RDA;
					end
				end
				ST_RDA: begin
					state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					active_q <= cur_q;
					ent_q <= rdata;
					if (size_head_q != NONE)
						size_head_q <= rdata.link;
					else
						sweep_head_q <= rdata.link;
					state_q <= ST_UPD;
				end
				ST_OUT: begin
					if (out_load) begin
						res_q <= pend_res_q;
						out_last_q <= pend_last_q;
						state_q <= ret_q;
					end
				end
				ST_CRD: begin
					if (!busy_q || active_q == NONE)
						state_q <= ST_IDLE;
					else
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (stat_q || issued_q == CMD_SIZE ||
						(issued_q != CMD_SEEK && rdata.rem <= 16'd1)) begin
						pend_res_q <= '{result_kind: RK_DONE, done_tag: rdata.tag,
							done_status: stat_q,
							track_total: (stat_q || issued_q != CMD_SIZE) ? 16'd0 : tracks_q,
							default: '0};
						free_q[active_q[AW-1:0]] <= 1'b1;
						active_q <= NONE;
						busy_q <= 1'b0;
						pend_last_q <= (size_head_q == NONE && sweep_head_q == NONE &&
							wrap_head_q == NONE);
						ret_q <= ST_DISP;
						state_q <= ST_OUT;
					end else begin
						ent_q <= step_ent;
						busy_q <= 1'b0;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (ent_q.kind == OP_SIZE) begin
						pend_res_q <= '{result_kind: RK_CMD, command: CMD_SIZE, default: '0};
						issued_q <= CMD_SIZE;
					end else if (ent_q.trk != head_track_q) begin
						head_track_q <= ent_q.trk;
						pend_res_q <= '{result_kind: RK_CMD, command: CMD_SEEK,
							command_argument: ent_q.trk, default: '0};
						issued_q <= CMD_SEEK;
					end else begin
						pend_res_q <= '{result_kind: RK_CMD,
							command: (ent_q.kind == OP_READ) ? CMD_READ : CMD_WRITE,
							command_argument: ent_q.sec, command_buffer: ent_q.buff,
							default: '0};
						issued_q <= (ent_q.kind == OP_READ) ? CMD_READ : CMD_WRITE;
					end
					busy_q <= 1'b1;
					pend_last_q <= 1'b1;
					ret_q <= ST_IDLE;
					state_q <= ST_OUT;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/elevator_disk_request_scheduler_top_tb.sv =====
// Testbench for the elevator disk request scheduler: drives request and completion words,
// predicts every command, done and reject word with a queue model and checks them in order.
// Depends on edrs_pkg and the scheduler RTL.
module elevator_disk_request_scheduler_top_tb;
	import edrs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NQ = DEF_QUEUE_DEPTH;
	localparam int SPT = DEF_SECTORS_PER_TRACK;
	localparam int SB = DEF_SECTOR_BYTES;
	localparam int LIMIT = 2000000;

	typedef struct packed {
		logic [15:0] track_count;
		logic        completion_status;
		logic [7:0]  request_tag;
		logic [31:0] buffer_address;
		logic [15:0] sector_count;
		logic [4:0]  start_sector;
		logic [15:0] track;
		logic [1:0]  operation;
	} request_t;

	typedef struct packed {
		result_t r;
		logic    last;
	} expect_t;

	class disk_scoreboard;
		logic [1:0]  kind[NQ];
		logic [15:0] trk[NQ];
		logic [15:0] sec[NQ];
		logic [15:0] rem[NQ];
		logic [31:0] buf_a[NQ];
		logic [7:0]  tag[NQ];
		int          link[NQ];
		bit          free_e[NQ];
		int          size_h, sweep_h, wrap_h, act;
		logic [15:0] head;
		bit          busy;
		logic [1:0]  issued;
		expect_t     pending[$];
		expect_t     step[$];
		int          errors, results, rejects, dones;

		function new();
			for (int i = 0; i < NQ; i++) free_e[i] = 1;
			size_h = NQ; sweep_h = NQ; wrap_h = NQ; act = NQ;
			head = 16'd0; busy = 0; issued = CMD_SEEK;
		endfunction

		function void push(logic [1:0] k, logic [1:0] c, logic [15:0] a, logic [31:0] b,
				logic [7:0] t, logic s, logic [15:0] d);
			expect_t x;
			x.r.result_kind = k; x.r.command = c; x.r.command_argument = a;
			x.r.command_buffer = b; x.r.done_tag = t; x.r.done_status = s;
			x.r.track_total = d; x.last = 1'b0;
			step.push_back(x);
		endfunction

		function void issue_cmd();
			logic [1:0] c;
			logic [15:0] a;
			logic [31:0] b;
			a = 16'd0; b = 32'd0;
			if (kind[act] == OP_SIZE) c = CMD_SIZE;
			else if (trk[act] != head) begin
				head = trk[act]; c = CMD_SEEK; a = trk[act];
			end else begin
				c = (kind[act] == OP_READ) ? CMD_READ : CMD_WRITE;
				a = sec[act]; b = buf_a[act];
			end
			busy = 1; issued = c;
			push(RK_CMD, c, a, b, 8'd0, 1'b0, 16'd0);
		endfunction

		function void start_next();
			if (busy) return;
			if (size_h != NQ) begin
				act = size_h; size_h = link[size_h]; issue_cmd(); return;
			end
			if (sweep_h == NQ) begin
				sweep_h = wrap_h; wrap_h = NQ;
			end
			if (sweep_h == NQ) return;
			act = sweep_h; sweep_h = link[sweep_h]; issue_cmd();
		endfunction

		function void retire(logic s, logic [15:0] d);
			push(RK_DONE, CMD_SEEK, 16'd0, 32'd0, tag[act], s, d);
			dones++;
			free_e[act] = 1; act = NQ; busy = 0;
			start_next();
		endfunction

		function void note_input(request_t q);
			int e, p, prv;
			bit bad;
			step.delete();
			if (q.operation == OP_DONE) begin
				if (busy && act != NQ) begin
					e = act;
					if (q.completion_status) retire(1'b1, 16'd0);
					else if (issued == CMD_SIZE) retire(1'b0, q.track_count);
					else if (issued != CMD_SEEK && rem[e] <= 1) retire(1'b0, 16'd0);
					else begin
						if (issued != CMD_SEEK) begin
							rem[e]--; sec[e]++; buf_a[e] += 32'(SB);
							if (sec[e] >= SPT) begin
								trk[e]++; sec[e] = 16'd0;
							end
						end
						busy = 0; issue_cmd();
					end
				end
			end else begin
				bad = q.operation != OP_SIZE && (q.start_sector >= SPT ||
					q.sector_count == 0 || q.buffer_address == 0);
				e = NQ;
				if (!bad)
					for (int i = 0; i < NQ; i++)
						if (free_e[i] && e == NQ) begin
							free_e[i] = 0; e = i;
						end
				if (e == NQ) begin
					push(RK_REJECT, CMD_SEEK, 16'd0, 32'd0, q.request_tag, 1'b0, 16'd0);
					rejects++;
				end else begin
					kind[e] = q.operation; tag[e] = q.request_tag;
					if (q.operation == OP_SIZE) begin
						trk[e] = 16'd0; sec[e] = 16'd0; rem[e] = 16'd0; buf_a[e] = 32'd0;
						link[e] = size_h; size_h = e;
					end else begin
						trk[e] = q.track; sec[e] = 16'(q.start_sector);
						rem[e] = q.sector_count; buf_a[e] = q.buffer_address;
						// walk to insertion point; prv == NQ means list head
						p = (q.track >= head) ? sweep_h : wrap_h;
						prv = NQ;
						while (p != NQ && trk[p] < q.track) begin
							prv = p; p = link[p];
						end
						link[e] = p;
						if (prv != NQ) link[prv] = e;
						else if (q.track >= head) sweep_h = e;
						else wrap_h = e;
					end
					start_next();
				end
			end
			if (step.size() > 0) step[step.size()-1].last = 1'b1;
			foreach (step[i]) pending.push_back(step[i]);
		endfunction

		function void check_result(result_t r, logic l);
			expect_t x;
			results++;
			if (pending.size() == 0) begin
				$error("unexpected word kind=%0d", r.result_kind);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (r.result_kind !== x.r.result_kind) begin
				$error("result_kind exp %0d got %0d", x.r.result_kind, r.result_kind); errors++;
			end
			if (r.command !== x.r.command) begin
				$error("command exp %0d got %0d", x.r.command, r.command); errors++;
			end
			if (r.command_argument !== x.r.command_argument) begin
				$error("command_argument exp %0d got %0d", x.r.command_argument,
					r.command_argument); errors++;
			end
			if (r.command_buffer !== x.r.command_buffer) begin
				$error("command_buffer exp %h got %h", x.r.command_buffer, r.command_buffer);
				errors++;
			end
			if (r.done_tag !== x.r.done_tag) begin
				$error("done_tag exp %0d got %0d", x.r.done_tag, r.done_tag); errors++;
			end
			if (r.done_status !== x.r.done_status) begin
				$error("done_status exp %0d got %0d", x.r.done_status, r.done_status); errors++;
			end
			if (r.track_total !== x.r.track_total) begin
				$error("track_total exp %0d got %0d", x.r.track_total, r.track_total); errors++;
			end
			if (l !== x.last) begin
				$error("last exp %0d got %0d", x.last, l); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tlast;
	logic [IN_BYTES_W-1:0] s_tdata;
	logic [OUT_BYTES_W-1:0] m_tdata;

	disk_scoreboard sb;
	int cycles;
	bit stall_long;
	bit in_done;

	elevator_disk_request_scheduler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_word(request_t q);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= IN_BYTES_W'(q);
		do @(posedge clk); while (!s_tready);
		sb.note_input(q);
	endtask

	function automatic request_t make_sub(logic [1:0] op, logic [15:0] t, logic [4:0] s,
			logic [15:0] n, logic [31:0] b);
		request_t q;
		q = request_t'({$urandom, $urandom, $urandom});
		q.operation = op; q.track = t; q.start_sector = s;
		q.sector_count = n; q.buffer_address = b;
		return q;
	endfunction

	function automatic request_t make_cpl(logic st);
		request_t q;
		q = request_t'({$urandom, $urandom, $urandom});
		q.operation = OP_DONE;
		q.completion_status = st;
		return q;
	endfunction

	task automatic drain_active(int max_words);
		int k;
		k = 0;
		while (sb.busy && k < max_words) begin
			send_word(make_cpl($urandom_range(0, 15) == 0));
			k++;
		end
	endtask

	initial begin
		request_t q;
		int r;
		sb = new();
		s_tvalid = 0; s_tdata = '0;
		@(posedge arst_n);
		repeat (2) @(posedge clk);
		// directed
		send_word(make_cpl(1'b0));
		send_word(make_sub(OP_READ, 16'hFFFF, 5'd15, 16'd3, 32'hFFFF_FE00));
		send_word(make_sub(OP_SIZE, 16'd0, 5'd0, 16'd0, 32'd0));
		send_word(make_sub(OP_WRITE, 16'd0, 5'd0, 16'd1, 32'd4));
		send_word(make_sub(OP_READ, 16'd5, 5'd16, 16'd1, 32'd8));
		send_word(make_sub(OP_READ, 16'd5, 5'd31, 16'd1, 32'd8));
		send_word(make_sub(OP_WRITE, 16'd5, 5'd2, 16'd0, 32'd8));
		send_word(make_sub(OP_WRITE, 16'd5, 5'd2, 16'hFFFF, 32'd0));
		send_word(make_cpl(1'b0));
		drain_active(20);
		for (int i = 0; i < 17; i++)
			send_word(make_sub(i[0] ? OP_SIZE : OP_WRITE, 16'(i * 3), 5'(i % 16),
				16'd2, 32'hFFFF_FFFF));
		drain_active(200);
		// random
		for (int i = 0; i < 900; i++) begin
			r = $urandom_range(0, 9);
			if (r < 3) begin
				q = make_sub(2'($urandom_range(0, 1)), 16'($urandom_range(0, 3) == 0 ?
					$urandom : $urandom_range(0, 40)), 5'($urandom_range(0, 15)),
					16'($urandom_range(1, 20)), $urandom | 32'd1);
				if ($urandom_range(0, 15) == 0) q.start_sector = 5'($urandom);
				if ($urandom_range(0, 15) == 0) q.sector_count = 16'd0;
				if ($urandom_range(0, 31) == 0) q.buffer_address = 32'd0;
				if ($urandom_range(0, 31) == 0) q.sector_count = 16'($urandom);
				send_word(q);
			end else if (r == 3) begin
				send_word(make_sub(OP_SIZE, 16'($urandom), 5'($urandom), 16'($urandom),
					$urandom));
			end else begin
				send_word(make_cpl($urandom_range(0, 19) == 0));
			end
		end
		drain_active(100);
		s_tvalid <= 0;
		in_done = 1;
	end

	initial begin
		int gap;
		m_tready = 0;
		stall_long = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stall_long && sb.pending.size() > 0 && cycles > 2000) begin
				stall_long = 1;
				m_tready <= 0;
				repeat (300) @(posedge clk);
			end
			gap = $urandom_range(0, 7) < 4 ? 0 : $urandom_range(1, 4);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(result_t'(m_tdata[OUT_W-1:0]), m_tlast);

	initial begin
		wait (in_done);
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d result words: %0d done, %0d rejected, long output stall",
			sb.results, sb.dones, sb.rejects);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
